/* sv/rlkd_pkg.sv */
// Shared constants for the resistor ladder key decoder: sample scaling,
// key table geometry and configuration register map.
// No dependencies.
package rlkd_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int SAMPLE_BITS = 12;

	localparam int MV_W      = 12;
	localparam int KEY_W     = 4;
	localparam int ENTRY_W   = MV_W + KEY_W;
	localparam int ENTRY_IDX_W = 3;
	localparam int COUNT_W   = 4;
	localparam int POLLS_W   = 8;

	localparam int FULL_MV     = 3300;
	localparam int SAMPLE_FULL = (1 << SAMPLE_BITS) - 1;

	// raw * 3300 fits in SAMPLE_BITS + 12 bits
	localparam int PROD_W = SAMPLE_BITS + MV_W;
	// p + (p << SAMPLE_BITS), reciprocal of the full scale
	localparam int SUM_W  = PROD_W + SAMPLE_BITS + 1;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_TABLE_LO = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_HI = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TOL      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_POLLS    = 3'd4;

	localparam logic [MV_W-1:0]    TOL_RESET   = 12'd100;
	localparam logic [POLLS_W-1:0] POLLS_RESET = 8'd1;
	localparam logic [KEY_W-1:0]   KEY_NONE    = 4'd0;

endpackage

/* sv/resistor_ladder_key_decoder_top.sv */
// Resistor ladder keypad decoder: sample scaling, nearest table entry search
// and debounce, with an APB-style configuration port. Depends on rlkd_pkg.
//
// Input stream: one beat per keypad poll; s_tdata[11:0] raw ADC sample (bits
// 15:12 zero), s_tuser the read-ok flag. Output stream: one beat per poll;
// m_tdata[3:0] pressed key (0 when no new press), [7:4] decoded key, [19:8] mV.
// Configuration: 64-bit registers at byte addresses 0, 8, 16, 24, 32 (table
// low word, table high word, entry count, tolerance, stable polls); write
// them only while no poll is in flight.
// Sequence: a good read takes a multiply step, two divide steps (reciprocal
// estimate, correction), a comparator step per valid table entry and a
// debounce step that loads the output register and raises m_tvalid. A failed
// read skips straight to that debounce step.
// One poll is in flight at a time; s_tready is high only while idle.
// Reset: arst_n clears the debounce state and the last key and millivolts,
// drops m_tvalid and loads register defaults (tolerance 100 mV, stable polls 1,
// empty table).
// Stall: a result waits in the output register; the sequencer holds in its
// last step until m_tready frees the register, and the input stays blocked.
module resistor_ladder_key_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: sample_raw [11:0], zero [15:12]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rlkd_pkg::IN_DATA_W-1:0]    s_tdata,
	// s_tuser: read_ok [0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: pressed_key [3:0], current_key [7:4], sample_mv [19:8], zero [23:20]
	output logic [rlkd_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rlkd_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [rlkd_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [rlkd_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import rlkd_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_CORR   = 3'd3;
	localparam logic [2:0] ST_SEARCH = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	// Configuration registers
	logic [CFG_DATA_W-1:0] table_lo_q;
	logic [CFG_DATA_W-1:0] table_hi_q;
	logic [COUNT_W-1:0]    entry_count_q;
	logic [MV_W-1:0]       tol_q;
	logic [POLLS_W-1:0]    polls_q;

	// Sequencer and datapath
	logic [2:0]             state_q;
	logic [SAMPLE_BITS-1:0] raw_q;
	logic                   ok_q;
	logic [PROD_W-1:0]      prod_q;
	logic [MV_W-1:0]        mv_q;
	logic [COUNT_W-1:0]     idx_q;
	logic [MV_W-1:0]        near_dist_q;
	logic [KEY_W-1:0]       near_key_q;
	logic                   found_q;

	// Debounce state
	logic [KEY_W-1:0]   cand_q;
	logic [POLLS_W-1:0] agree_q;
	logic [KEY_W-1:0]   latched_q;
	logic [KEY_W-1:0]   last_key_q;
	logic [MV_W-1:0]    last_mv_q;

	// Output register
	logic               m_tvalid_q;
	logic [KEY_W-1:0]   out_pressed_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [MV_W-1:0]    out_mv_q;

	logic                   cfg_wr;
	logic [REG_IDX_W-1:0]   reg_idx;
	logic [2*CFG_DATA_W-1:0] table_all;
	logic [COUNT_W-1:0]     n_eff;
	logic [ENTRY_W-1:0]     entry_w;
	logic [MV_W-1:0]        entry_mv;
	logic [MV_W-1:0]        delta;
	logic                   take_entry;
	logic [SUM_W-1:0]       recip_sum;
	logic [PROD_W-1:0]      q_times_full;
	logic [PROD_W-1:0]      div_rem;
	logic                   out_free;
	logic                   load_out;
	logic [KEY_W-1:0]       dec_key;

	// ---------------------------------------------------------------
	// Configuration port: zero wait states, decode on the 8-byte slot
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (reg_idx)
			REG_TABLE_LO: prdata = table_lo_q;
			REG_TABLE_HI: prdata = table_hi_q;
			REG_COUNT:    prdata = CFG_DATA_W'(entry_count_q);
			REG_TOL:      prdata = CFG_DATA_W'(tol_q);
			REG_POLLS:    prdata = CFG_DATA_W'(polls_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_lo_q    <= '0;
			table_hi_q    <= '0;
			entry_count_q <= '0;
			tol_q         <= TOL_RESET;
			polls_q       <= POLLS_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TABLE_LO: table_lo_q    <= pwdata;
				REG_TABLE_HI: table_hi_q    <= pwdata;
				REG_COUNT:    entry_count_q <= pwdata[COUNT_W-1:0];
				REG_TOL:      tol_q         <= pwdata[MV_W-1:0];
				REG_POLLS:    polls_q       <= pwdata[POLLS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Datapath
	// ---------------------------------------------------------------
	// Clamp the entry count to the table size
	assign n_eff = (entry_count_q > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
	                                                       : entry_count_q;

	assign table_all = {table_hi_q, table_lo_q};
	assign entry_w   = table_all[{idx_q[ENTRY_IDX_W-1:0], 4'b0000} +: ENTRY_W];
	assign entry_mv  = entry_w[MV_W-1:0];

	// Shared distance comparator, one table entry per cycle
	assign delta      = (mv_q >= entry_mv) ? (mv_q - entry_mv) : (entry_mv - mv_q);
	assign take_entry = (idx_q == '0) || (delta < near_dist_q);

	// Divide by 2^B-1: estimate with (p + p<<B) >> 2B, which is q or q-1
	assign recip_sum    = SUM_W'(prod_q) + (SUM_W'(prod_q) << SAMPLE_BITS);
	assign q_times_full = (PROD_W'(mv_q) << SAMPLE_BITS) - PROD_W'(mv_q);
	assign div_rem      = prod_q - q_times_full;

	// Nearest entry within tolerance, else none
	assign dec_key = (found_q && (near_dist_q <= tol_q)) ? near_key_q : KEY_NONE;

	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = (state_q == ST_DONE) && out_free;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= s_tuser ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= (n_eff == '0) ? ST_DONE : ST_SEARCH;
				end
				ST_SEARCH: begin
					found_q <= 1'b1;
					idx_q   <= idx_q + 1'b1;
					if (idx_q + 1'b1 == n_eff) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_q <= s_tdata[SAMPLE_BITS-1:0];
			ok_q  <= s_tuser;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(raw_q) * PROD_W'(FULL_MV);
		end
		if (state_q == ST_DIV) begin
			mv_q <= recip_sum[2*SAMPLE_BITS +: MV_W];
		end
		if (state_q == ST_CORR && div_rem >= PROD_W'(SAMPLE_FULL)) begin
			mv_q <= mv_q + 1'b1;
		end
		if (state_q == ST_SEARCH && take_entry) begin
			near_dist_q <= delta;
			near_key_q  <= entry_w[ENTRY_W-1 -: KEY_W];
		end
	end

	// ---------------------------------------------------------------
	// Debounce and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q        <= KEY_NONE;
			agree_q       <= '0;
			latched_q     <= KEY_NONE;
			last_key_q    <= KEY_NONE;
			last_mv_q     <= '0;
			m_tvalid_q    <= 1'b0;
			out_pressed_q <= KEY_NONE;
			out_key_q     <= KEY_NONE;
			out_mv_q      <= '0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (load_out) begin
				if (ok_q) begin
					last_key_q <= dec_key;
					last_mv_q  <= mv_q;
					out_key_q  <= dec_key;
					out_mv_q   <= mv_q;
					if (dec_key == KEY_NONE) begin
						// Release: drop candidate and latch
						cand_q        <= KEY_NONE;
						agree_q       <= '0;
						latched_q     <= KEY_NONE;
						out_pressed_q <= KEY_NONE;
					end else if (dec_key != cand_q) begin
						cand_q        <= dec_key;
						agree_q       <= POLLS_W'(1);
						out_pressed_q <= KEY_NONE;
					end else if (agree_q < polls_q) begin
						agree_q       <= agree_q + 1'b1;
						out_pressed_q <= KEY_NONE;
					end else if (latched_q != dec_key) begin
						latched_q     <= dec_key;
						out_pressed_q <= dec_key;
					end else begin
						out_pressed_q <= KEY_NONE;
					end
				end else begin
					// Failed read: repeat the last good sample, hold the debounce state
					out_pressed_q <= KEY_NONE;
					out_key_q     <= last_key_q;
					out_mv_q      <= last_mv_q;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_mv_q, out_key_q, out_pressed_q};

`ifndef NO_ASSERTIONS
	// A candidate key and a nonzero agreement count always go together
	a_cand_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(cand_q == KEY_NONE) == (agree_q == '0))
		else $error("candidate and agreement count out of step");

	// One poll in flight: input blocks right after a beat is taken
	a_one_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a poll is in flight");

	// The search never visits an entry past the clamped count
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (idx_q < n_eff))
		else $error("table search ran past the entry count");

	// Scaled sample stays within full-scale millivolts
	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (mv_q <= MV_W'(FULL_MV)))
		else $error("scaled sample above full scale");
`endif

endmodule
